>>> rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/nsd_pkg.sv
// Package: widths, status codes and interface structs of the distance accumulator
package nsd_pkg;

	localparam int SUM_W             = 64;
	localparam int PROD_W            = 2 * SUM_W;
	localparam int ALU_W             = PROD_W + 1;
	localparam int RATIO_W           = 32;
	localparam int STATUS_W          = 2;
	localparam int CNT_W             = $clog2(SUM_W);
	localparam int DEF_COUNT_BITS    = 16;
	localparam int DEF_FRACTION_BITS = 16;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SAT  = 2'd2;

	typedef struct packed {
		logic [SUM_W-1:0] d_sum;
		logic [SUM_W-1:0] a_sum;
		logic [SUM_W-1:0] b_sum;
	} nsd_sums_t;

	typedef struct packed {
		logic busy;
		logic start;
		logic ovf;
	} nsd_acc_stat_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} nsd_alu_req_t;

	typedef struct packed {
		logic [RATIO_W-1:0]  ratio;
		logic [STATUS_W-1:0] status;
	} nsd_res_t;

endpackage

>>> rtl/core/nsd_accum.sv
// Accumulator: squares each pair on one multiplier and keeps three saturating sums
module nsd_accum import nsd_pkg::*; #(
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [COUNT_BITS-1:0] cnt_a,
	input  logic [COUNT_BITS-1:0] cnt_b,
	input  logic                  last_in,
	input  logic                  clear,
	output nsd_sums_t             sums,
	output nsd_acc_stat_t         stat
);

	localparam int PW = 2 * COUNT_BITS;

	logic [COUNT_BITS-1:0] op_q [3];
	logic [PW-1:0]         prod_q;
	logic [SUM_W-1:0]      sum_q [3];
	logic [1:0]            ph_q;
	logic                  busy_q;
	logic                  hold_q;
	logic                  last_q;
	logic                  ovf_q;
	logic                  start_q;

	logic [COUNT_BITS-1:0] mul_op;
	logic [SUM_W-1:0]      cur_sum;
	logic [SUM_W:0]        add_t;
	logic                  adding;

	// pick the operand to square this phase
	always_comb begin
		case (ph_q)
			2'd0:    mul_op = op_q[0];
			2'd1:    mul_op = op_q[1];
			default: mul_op = op_q[2];
		endcase
	end

	// pick the sum that takes the product squared last phase
	always_comb begin
		case (ph_q)
			2'd1:    cur_sum = sum_q[0];
			2'd2:    cur_sum = sum_q[1];
			default: cur_sum = sum_q[2];
		endcase
	end

	assign adding = busy_q && !hold_q && (ph_q != 2'd0);
	assign add_t  = (SUM_W+1)'(cur_sum) + (SUM_W+1)'(prod_q);

	// square, accumulate and hold until the result has been computed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			hold_q   <= 1'b0;
			ph_q     <= 2'd0;
			last_q   <= 1'b0;
			ovf_q    <= 1'b0;
			start_q  <= 1'b0;
			sum_q[0] <= '0;
			sum_q[1] <= '0;
			sum_q[2] <= '0;
		end else begin
			start_q <= 1'b0;
			if (clear) begin
				busy_q   <= 1'b0;
				hold_q   <= 1'b0;
				ovf_q    <= 1'b0;
				sum_q[0] <= '0;
				sum_q[1] <= '0;
				sum_q[2] <= '0;
			end else if (take) begin
				busy_q <= 1'b1;
				ph_q   <= 2'd0;
				last_q <= last_in;
			end else if (busy_q && !hold_q) begin
				ph_q <= ph_q + 2'd1;
				if (adding) begin
					if (add_t[SUM_W]) begin
						ovf_q <= 1'b1;
					end
					case (ph_q)
						2'd1:    sum_q[0] <= add_t[SUM_W] ? '1 : add_t[SUM_W-1:0];
						2'd2:    sum_q[1] <= add_t[SUM_W] ? '1 : add_t[SUM_W-1:0];
						default: sum_q[2] <= add_t[SUM_W] ? '1 : add_t[SUM_W-1:0];
					endcase
				end
				if (ph_q == 2'd3) begin
					if (last_q) begin
						hold_q  <= 1'b1;
						start_q <= 1'b1;
					end else begin
						busy_q <= 1'b0;
					end
				end
			end
		end
	end

	// capture operands and the absolute difference; square one per cycle
	always_ff @(posedge clk) begin
		if (take) begin
			op_q[0] <= (cnt_a > cnt_b) ? cnt_a - cnt_b : cnt_b - cnt_a;
			op_q[1] <= cnt_a;
			op_q[2] <= cnt_b;
		end
		prod_q <= PW'(mul_op) * PW'(mul_op);
	end

	assign sums.d_sum = sum_q[0];
	assign sums.a_sum = sum_q[1];
	assign sums.b_sum = sum_q[2];
	assign stat.busy  = busy_q;
	assign stat.start = start_q;
	assign stat.ovf   = ovf_q;

endmodule

>>> rtl/core/nsd_alu.sv
// Shared wide add/subtract unit with carry out
module nsd_alu import nsd_pkg::*; (
	input  nsd_alu_req_t     req,
	output logic [ALU_W-1:0] res,
	output logic             cout
);

	logic [ALU_W:0] t;

	// subtract as add of the inverted operand plus one; carry set means a >= b
	assign t    = {1'b0, req.a} + {1'b0, req.b ^ {ALU_W{req.sub}}} + (ALU_W+1)'(req.sub);
	assign res  = t[ALU_W-1:0];
	assign cout = t[ALU_W];

endmodule

>>> rtl/core/nsd_engine.sv
// Sequencer: multiply, divide and square root one bit per cycle on the shared unit
module nsd_engine import nsd_pkg::*; #(
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  nsd_sums_t sums,
	input  logic      ovf,
	input  logic      load_ok,
	output logic      busy,
	output logic      done,
	output nsd_res_t  res
);

	localparam int R_W = PROD_W + 2 * FRACTION_BITS;
	localparam logic [CNT_W-1:0] LAST_BIT  = CNT_W'(SUM_W - 1);
	localparam logic [CNT_W-1:0] LAST_ROOT = CNT_W'(RATIO_W - 1);

	typedef enum logic [2:0] {
		E_IDLE,
		E_MULP,
		E_MULD,
		E_DCHK,
		E_DIV,
		E_SQRT,
		E_DONE
	} state_t;

	state_t             state_q;
	logic [PROD_W-1:0]  acc_q;
	logic [PROD_W-1:0]  p_q;
	logic [SUM_W-1:0]   mr_q;
	logic [SUM_W-1:0]   lo_q;
	logic [SUM_W-1:0]   q_q;
	logic [ALU_W-1:0]   rem_q;
	logic [RATIO_W-1:0] root_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               ovf_q;
	nsd_res_t           res_q;

	nsd_alu_req_t       req;
	logic [ALU_W-1:0]   alu_res;
	logic               alu_cout;
	logic [R_W-1:0]     r_full;

	nsd_alu u_alu (
		.req  (req),
		.res  (alu_res),
		.cout (alu_cout)
	);

	// route operands of the current step to the shared unit
	always_comb begin
		req = '0;
		case (state_q)
			E_MULP: begin
				req.a = ALU_W'({acc_q[PROD_W-2:0], 1'b0});
				req.b = mr_q[SUM_W-1] ? ALU_W'(sums.b_sum) : '0;
			end
			E_MULD: begin
				req.a = ALU_W'({acc_q[PROD_W-2:0], 1'b0});
				req.b = mr_q[SUM_W-1] ? ALU_W'(sums.d_sum) : '0;
			end
			E_DCHK: begin
				req.a   = rem_q;
				req.b   = ALU_W'(p_q);
				req.sub = 1'b1;
			end
			E_DIV: begin
				req.a   = {rem_q[PROD_W-1:0], lo_q[SUM_W-1]};
				req.b   = ALU_W'(p_q);
				req.sub = 1'b1;
			end
			E_SQRT: begin
				req.a   = ALU_W'({rem_q[RATIO_W:0], q_q[SUM_W-1 -: 2]});
				req.b   = ALU_W'({root_q, 2'b01});
				req.sub = 1'b1;
			end
			default: req = '0;
		endcase
	end

	// scaled squared difference sum: dividend of the division
	assign r_full = R_W'(alu_res[PROD_W-1:0]) << (2 * FRACTION_BITS);

	// step the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			acc_q   <= '0;
			p_q     <= '0;
			mr_q    <= '0;
			lo_q    <= '0;
			q_q     <= '0;
			rem_q   <= '0;
			root_q  <= '0;
			res_q   <= '0;
		end else begin
			case (state_q)
				E_IDLE: begin
					if (start) begin
						ovf_q <= ovf;
						if (sums.a_sum == '0 || sums.b_sum == '0) begin
							res_q.ratio  <= '0;
							res_q.status <= ST_ZERO;
							state_q      <= E_DONE;
						end else begin
							acc_q   <= '0;
							mr_q    <= sums.a_sum;
							cnt_q   <= LAST_BIT;
							state_q <= E_MULP;
						end
					end
				end
				E_MULP: begin
					acc_q <= alu_res[PROD_W-1:0];
					mr_q  <= mr_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						p_q     <= alu_res[PROD_W-1:0];
						acc_q   <= '0;
						mr_q    <= sums.d_sum;
						cnt_q   <= LAST_BIT;
						state_q <= E_MULD;
					end
				end
				E_MULD: begin
					acc_q <= alu_res[PROD_W-1:0];
					mr_q  <= mr_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						rem_q   <= ALU_W'(r_full[R_W-1:SUM_W]);
						lo_q    <= r_full[SUM_W-1:0];
						state_q <= E_DCHK;
					end
				end
				E_DCHK: begin
					if (alu_cout) begin
						// quotient reaches 2^64: root reaches 2^32
						res_q.ratio  <= '1;
						res_q.status <= ST_SAT;
						state_q      <= E_DONE;
					end else begin
						cnt_q   <= LAST_BIT;
						q_q     <= '0;
						state_q <= E_DIV;
					end
				end
				E_DIV: begin
					rem_q <= alu_cout ? alu_res : req.a;
					q_q   <= {q_q[SUM_W-2:0], alu_cout};
					lo_q  <= lo_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						rem_q   <= '0;
						root_q  <= '0;
						cnt_q   <= LAST_ROOT;
						state_q <= E_SQRT;
					end
				end
				E_SQRT: begin
					rem_q  <= alu_cout ? alu_res : req.a;
					root_q <= {root_q[RATIO_W-2:0], alu_cout};
					q_q    <= q_q << 2;
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						res_q.ratio  <= {root_q[RATIO_W-2:0], alu_cout};
						res_q.status <= ovf_q ? ST_SAT : ST_OK;
						state_q      <= E_DONE;
					end
				end
				E_DONE: begin
					if (load_ok) begin
						state_q <= E_IDLE;
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	assign busy = (state_q != E_IDLE);
	assign done = (state_q == E_DONE) && load_ok;
	assign res  = res_q;

endmodule

>>> rtl/core/normalized_sq_distance_accum.sv
// Normalised squared-distance accumulator: top level with handshakes and result register
// Each pair is accepted, then item_stall stays high while it is squared and summed on one
// multiplier; after a pair marked last it stays high until the result has been loaded.
// A pair marked last then runs two 64-step multiplies, 65 divide steps and 32 root steps
// on the shared 129-bit add/subtract unit before the result is registered.
// A zero norm product or a saturated quotient ends the sequence early.
// Reset clears all sums, the overflow flag, the sequencer and result_valid.
`include "assert_macros.svh"

module normalized_sq_distance_accum import nsd_pkg::*; #(
	parameter int COUNT_BITS    = DEF_COUNT_BITS,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [COUNT_BITS-1:0] count_a,
	input  logic [COUNT_BITS-1:0] count_b,
	input  logic                  last,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [RATIO_W-1:0]    ratio,
	output logic [STATUS_W-1:0]   status
);

	nsd_sums_t           sums;
	nsd_acc_stat_t       acc_stat;
	nsd_res_t            eng_res;
	logic                eng_busy;
	logic                eng_done;
	logic                take;
	logic                load_ok;
	logic                result_valid_q;
	logic [RATIO_W-1:0]  ratio_q;
	logic [STATUS_W-1:0] status_q;

	assign item_stall = acc_stat.busy;
	assign take       = item_valid && !item_stall;
	assign load_ok    = !result_valid_q || !result_stall;

	nsd_accum #(
		.COUNT_BITS (COUNT_BITS)
	) u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.cnt_a   (count_a),
		.cnt_b   (count_b),
		.last_in (last),
		.clear   (eng_done),
		.sums    (sums),
		.stat    (acc_stat)
	);

	nsd_engine #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (acc_stat.start),
		.sums    (sums),
		.ovf     (acc_stat.ovf),
		.load_ok (load_ok),
		.busy    (eng_busy),
		.done    (eng_done),
		.res     (eng_res)
	);

	// hold the result until the downstream transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (eng_done) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// load the result payload
	always_ff @(posedge clk) begin
		if (eng_done) begin
			ratio_q  <= eng_res.ratio;
			status_q <= eng_res.status;
		end
	end

	assign result_valid = result_valid_q;
	assign ratio        = ratio_q;
	assign status       = status_q;

	`ASSERT_NEXT(a_stall_after_take, take, item_stall)
	`ASSERT_IMP(a_stall_while_eng, eng_busy, item_stall)
	`ASSERT_IMP(a_zero_norm_ratio, result_valid_q && status_q == ST_ZERO, ratio_q == '0)

endmodule

>>> tb/normalized_sq_distance_accum_tb.sv
// Self-checking testbench for the normalised squared-distance accumulator
module normalized_sq_distance_accum_tb import nsd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB           = DEF_COUNT_BITS;
	localparam int FB           = DEF_FRACTION_BITS;
	localparam int RANDOM_ITEMS = 700;
	localparam int DRAIN_CYCLES = 400;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SHOWN_ERRORS = 10;

	typedef logic [255:0] wide_t;

	typedef enum int {
		STYLE_WIDE,
		STYLE_SMALL,
		STYLE_CLOSE,
		STYLE_ZERO_A,
		STYLE_ZERO_B,
		STYLE_SCALED
	} pair_style_t;

	logic                clk;
	logic                arst_n;
	logic                item_valid;
	logic                item_stall;
	logic [CB-1:0]       count_a;
	logic [CB-1:0]       count_b;
	logic                last;
	logic                result_valid;
	logic                result_stall;
	logic [RATIO_W-1:0]  ratio;
	logic [STATUS_W-1:0] status;

	// running sums of the vectors seen so far, as the block should hold them
	logic [SUM_W-1:0] diff_sum;
	logic [SUM_W-1:0] a_sum;
	logic [SUM_W-1:0] b_sum;
	logic             sum_overflow;

	nsd_res_t expected_ratios[$];
	int       mismatch_count;
	logic     idle_on;
	int       result_hold;

	normalized_sq_distance_accum i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.count_a      (count_a),
		.count_b      (count_b),
		.last         (last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.ratio        (ratio),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Add with clamping at all ones, noting the overflow
	function automatic logic [SUM_W-1:0] add_clamped(input logic [SUM_W-1:0] s,
			input logic [SUM_W-1:0] x);
		logic [SUM_W:0] t;
		t = {1'b0, s} + {1'b0, x};
		if (t[SUM_W]) begin
			sum_overflow = 1'b1;
			return '1;
		end
		return t[SUM_W-1:0];
	endfunction

	// Quotient d / sqrt(a * b) in fixed point, truncated, found bit by bit
	function automatic nsd_res_t norm_ratio();
		wide_t    prod;
		wide_t    rhs;
		wide_t    trial;
		nsd_res_t res;
		res.ratio  = '0;
		res.status = ST_OK;
		if (a_sum == '0 || b_sum == '0) begin
			res.status = ST_ZERO;
			return res;
		end
		prod = wide_t'(a_sum) * wide_t'(b_sum);
		rhs  = wide_t'(diff_sum) << FB;
		rhs  = rhs * rhs;
		// a quotient of 2^32 or more clamps
		if ((prod << 64) <= rhs) begin
			res.ratio  = '1;
			res.status = ST_SAT;
			return res;
		end
		for (int bit_i = RATIO_W - 1; bit_i >= 0; bit_i--) begin
			trial = wide_t'(res.ratio | (RATIO_W'(1) << bit_i));
			if (trial * trial * prod <= rhs) res.ratio = trial[RATIO_W-1:0];
		end
		if (sum_overflow) res.status = ST_SAT;
		return res;
	endfunction

	// Fold one accepted pair into the sums; on the last pair queue the ratio and clear
	task automatic accumulate_pair(input logic [CB-1:0] a, input logic [CB-1:0] b,
			input logic mark_last);
		logic [SUM_W-1:0] la;
		logic [SUM_W-1:0] lb;
		logic [SUM_W-1:0] d;
		la = SUM_W'(a);
		lb = SUM_W'(b);
		d  = (la > lb) ? la - lb : lb - la;
		diff_sum = add_clamped(diff_sum, d * d);
		a_sum    = add_clamped(a_sum, la * la);
		b_sum    = add_clamped(b_sum, lb * lb);
		if (mark_last) begin
			expected_ratios.push_back(norm_ratio());
			diff_sum     = '0;
			a_sum        = '0;
			b_sum        = '0;
			sum_overflow = 1'b0;
		end
	endtask

	// Offer one pair and hold it until the transaction is taken
	task automatic send_pair(input logic [CB-1:0] a, input logic [CB-1:0] b,
			input logic mark_last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		count_a    <= a;
		count_b    <= b;
		last       <= mark_last;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		accumulate_pair(a, b, mark_last);
	endtask

	// Compare one received transaction with the oldest queued ratio
	task automatic check_result();
		nsd_res_t want;
		if (expected_ratios.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= SHOWN_ERRORS)
				$display("unexpected result: ratio %h status %0d", ratio, status);
		end else begin
			want = expected_ratios.pop_front();
			if (ratio !== want.ratio || status !== want.status) begin
				mismatch_count++;
				if (mismatch_count <= SHOWN_ERRORS)
					$display("mismatch: expected ratio %h status %0d, got ratio %h status %0d",
						want.ratio, want.status, ratio, status);
			end
		end
	endtask

	// Take results and stall the output at random
	always @(posedge clk) begin
		int g;
		if (arst_n) begin
			if (result_valid && !result_stall) check_result();
			if (result_hold > 0) begin
				result_stall <= 1'b1;
				result_hold  <= result_hold - 1;
			end else begin
				g = pick_gap();
				result_stall <= (g > 0);
				result_hold  <= (g > 0) ? g - 1 : 0;
			end
		end else begin
			result_stall <= 1'b0;
			result_hold  <= 0;
		end
	end

	// Stop a hung run
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Identical vectors give a zero distance
	task automatic test_equal_vectors();
		send_pair('1, '1, 1'b0);
		send_pair('0, '0, 1'b0);
		send_pair(CB'(1), CB'(1), 1'b1);
	endtask

	// An all-zero vector on either side gives the zero-norm status
	task automatic test_zero_norm();
		send_pair('0, CB'(5), 1'b0);
		send_pair('0, '1, 1'b1);
		send_pair('1, '0, 1'b1);
		send_pair('0, '0, 1'b1);
	endtask

	// Distance far above the norm clamps the ratio
	task automatic test_ratio_saturation();
		send_pair(CB'(1), '0, 1'b0);
		send_pair('0, '1, 1'b0);
		send_pair('0, '1, 1'b1);
	endtask

	// Field extremes and alternating bit patterns, one-pair vectors mostly
	task automatic test_field_extremes();
		send_pair('1, CB'(1), 1'b1);
		send_pair(CB'(1), '1, 1'b1);
		send_pair(CB'(16'h8000), CB'(16'h7fff), 1'b1);
		send_pair(CB'(16'haaaa), CB'(16'h5555), 1'b0);
		send_pair(CB'(16'h5555), CB'(16'haaaa), 1'b1);
	endtask

	// Sums carry over unmarked pairs and start afresh after the last one
	task automatic test_sum_clear();
		send_pair(CB'(100), CB'(200), 1'b0);
		send_pair(CB'(300), CB'(50), 1'b1);
		send_pair(CB'(7), CB'(9), 1'b1);
	endtask

	// Draw one pair in the given shape
	task automatic draw_pair(input pair_style_t style, output logic [CB-1:0] a,
			output logic [CB-1:0] b);
		case (style)
			STYLE_SMALL: begin
				a = CB'($urandom_range(15));
				b = CB'($urandom_range(15));
			end
			STYLE_CLOSE: begin
				a = CB'($urandom);
				b = a ^ CB'($urandom_range(3));
			end
			STYLE_ZERO_A: begin
				a = '0;
				b = CB'($urandom);
			end
			STYLE_ZERO_B: begin
				a = CB'($urandom);
				b = '0;
			end
			STYLE_SCALED: begin
				a = CB'($urandom_range(255));
				b = CB'(a * $urandom_range(1, 200));
			end
			default: begin
				a = CB'($urandom);
				b = CB'($urandom);
			end
		endcase
	endtask

	// Random vectors: mostly short, a few long, one shape per vector
	task automatic test_random_vectors();
		int            sent;
		int            len;
		int            r;
		pair_style_t   style;
		logic [CB-1:0] a;
		logic [CB-1:0] b;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			idle_on = ($urandom_range(7) != 0);
			len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
			r = $urandom_range(99);
			if (r < 35)      style = STYLE_WIDE;
			else if (r < 55) style = STYLE_SMALL;
			else if (r < 75) style = STYLE_CLOSE;
			else if (r < 80) style = STYLE_ZERO_A;
			else if (r < 85) style = STYLE_ZERO_B;
			else             style = STYLE_SCALED;
			for (int i = 0; i < len; i++) begin
				draw_pair(style, a, b);
				send_pair(a, b, i == len - 1);
				sent++;
			end
		end
	endtask

	initial begin
		mismatch_count = 0;
		idle_on        = 1'b1;
		diff_sum       = '0;
		a_sum          = '0;
		b_sum          = '0;
		sum_overflow   = 1'b0;
		arst_n       <= 1'b0;
		item_valid   <= 1'b0;
		count_a      <= '0;
		count_b      <= '0;
		last         <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_equal_vectors();
		test_zero_norm();
		test_ratio_saturation();
		test_field_extremes();
		test_sum_clear();
		test_random_vectors();

		// drain: wait for every queued ratio, then let the block settle
		item_valid <= 1'b0;
		idle_on = 1'b1;
		while (expected_ratios.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_ratios.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/nsd_pkg.sv
rtl/core/nsd_accum.sv
rtl/core/nsd_alu.sv
rtl/core/nsd_engine.sv
rtl/core/normalized_sq_distance_accum.sv
tb/normalized_sq_distance_accum_tb.sv
